[design/ogc_pkg.sv]
// ----------------------------------------------------------------------------
// ogc_pkg: shared types and constants for the ADC offset/gain calibrator
// Word layouts, action codes, sequencer states and divider handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ogc_pkg;

    // Default block configuration
    localparam int FULL_SCALE_CODE_DEF = 4095;
    localparam int VREF_MILLIVOLTS_DEF = 3300;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int CODE_W   = 16;
    localparam int CORR_W   = 12;
    localparam int GAIN_W   = 16;

    // Shared multiplier and divider widths
    localparam int MUL_W      = 2 * CODE_W;
    localparam int DIVIDEND_W = MUL_W;
    localparam int DIVISOR_W  = CODE_W;
    localparam int DIV_STEPS  = DIVIDEND_W;

    // Arithmetic constants
    localparam logic [GAIN_W-1:0]    GAIN_RESET = GAIN_W'(1000);
    localparam logic [CODE_W-1:0]    PERMILLE   = CODE_W'(1000);
    localparam logic [DIVISOR_W-1:0] PERMILLE_DEN = DIVISOR_W'(1000);

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPLY    = 2'd0,
        ACT_SET_ZERO = 2'd1,
        ACT_SET_GAIN = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_FINISH
    } t_state;

    // What the pending division result is used for
    typedef enum logic [1:0] {
        PH_APPLY,
        PH_TARGET,
        PH_QUOT
    } t_phase;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   sample;
        logic [CODE_W-1:0]   expected_mv;
    } t_in_word;

    typedef struct packed {
        logic [CORR_W-1:0] corrected;
        logic              status;
    } t_out_word;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

[design/ogc_divider.sv]
// ----------------------------------------------------------------------------
// ogc_divider: iterative restoring divider
// Produces one quotient bit per cycle; pulses done with the full quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogc_divider (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ogc_pkg::t_div_req i_req,
    output ogc_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(ogc_pkg::DIV_STEPS);
    localparam int NUM_W = ogc_pkg::DIVIDEND_W;
    localparam int DEN_W = ogc_pkg::DIVISOR_W;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DEN_W-1:0] r_rem,  n_rem;
    logic [NUM_W-1:0] r_quo,  n_quo;
    logic [DEN_W-1:0] r_den,  n_den;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W+1:0] w_diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            // keep the remainder when the trial goes negative
            n_rem = w_diff[DEN_W+1] ? w_rem_sh[DEN_W-1:0] : w_diff[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], ~w_diff[DEN_W+1]};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(ogc_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

[design/adc_offset_gain_calibrator.sv]
// ----------------------------------------------------------------------------
// adc_offset_gain_calibrator: offset and gain correction of converter codes
// Each input word carries an action. Apply adds the stored offset to the raw
// code, multiplies by the gain in permille, divides by 1000 and clamps to
// 0..FULL_SCALE_CODE. Set-zero stores minus the code as the offset (codes
// above full scale are refused). Set-gain derives a new gain from a measured
// reference code and its voltage in millivolts. Every word returns exactly
// one result word; status 1 means the request was refused and nothing
// changed. One word is in flight at a time. Set-zero, requests refused in the
// check and an apply whose corrected sum is not positive skip the multiply
// and divide steps and go straight to the finish state. A finished result
// holds in place while the output register is still full, and the next word
// is taken in the cycle after the result is loaded. All division runs on the
// single shared 32-by-16 restoring divider, which yields one quotient bit per
// cycle (32 iterations per division, after a step each to multiply and to
// start the divider and a wait step to collect the quotient; set-gain divides
// twice).
// The finished result sits in an output register, so the next word is taken
// while the previous result still waits for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adc_offset_gain_calibrator #(
    parameter int FULL_SCALE_CODE = ogc_pkg::FULL_SCALE_CODE_DEF,
    parameter int VREF_MILLIVOLTS = ogc_pkg::VREF_MILLIVOLTS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  ogc_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output ogc_pkg::t_out_word o_out_data
);

    localparam int CODE_W = ogc_pkg::CODE_W;
    localparam int MUL_W  = ogc_pkg::MUL_W;
    localparam int GAIN_W = ogc_pkg::GAIN_W;
    localparam int CORR_W = ogc_pkg::CORR_W;
    localparam int DEN_W  = ogc_pkg::DIVISOR_W;
    // Offset lives in -FULL_SCALE_CODE..0
    localparam int OFS_W  = $clog2(FULL_SCALE_CODE + 1) + 1;
    // Sum of raw code and offset, one spare bit so the sign extension never vanishes
    localparam int SUM_W  = CODE_W + 2;

    localparam logic [CODE_W-1:0] FS_CODE   = CODE_W'(FULL_SCALE_CODE);
    localparam logic [CODE_W-1:0] VREF_CODE = CODE_W'(VREF_MILLIVOLTS);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ogc_pkg::t_state r_state, n_state;
    ogc_pkg::t_phase r_phase, n_phase;

    logic signed [OFS_W-1:0] r_offset, n_offset;
    logic [GAIN_W-1:0]       r_gain,   n_gain;
    logic                    r_out_valid, n_out_valid;

    // Working registers of the current word
    logic [ogc_pkg::ACTION_W-1:0] r_action, n_action;
    logic [CODE_W-1:0]            r_sample, n_sample;
    logic [CODE_W-1:0]            r_mv,     n_mv;
    logic [CODE_W-1:0]            r_mul_a,  n_mul_a;
    logic [CODE_W-1:0]            r_mul_b,  n_mul_b;
    logic [MUL_W-1:0]             r_prod,   n_prod;
    logic [DEN_W-1:0]             r_den,    n_den;
    logic [CODE_W-1:0]            r_base,   n_base;
    logic [CORR_W-1:0]            r_corr,   n_corr;
    logic                         r_status, n_status;
    ogc_pkg::t_out_word           r_out,    n_out;

    ogc_pkg::t_div_req w_div_req;
    ogc_pkg::t_div_rsp w_div_rsp;

    logic              w_accept;
    logic              w_slot_free;
    logic signed [SUM_W-1:0] w_sum;
    logic              w_sum_pos;
    logic              w_gain_bad;
    logic [CODE_W-1:0] w_clamped;
    logic              w_quot_bad;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Raw code plus offset, exact
    assign w_sum = $signed({2'b00, r_sample})
                 + $signed({{(SUM_W - OFS_W){r_offset[OFS_W-1]}}, r_offset});
    assign w_sum_pos = !w_sum[SUM_W-1] && (w_sum != '0);

    // Refuse set-gain on bad reference values or a non-positive corrected code
    assign w_gain_bad = (r_sample == '0) || (r_mv == '0) || (r_mv > VREF_CODE)
                     || !w_sum_pos;

    // Clamp the scaled code to full scale
    assign w_clamped = (w_div_rsp.quotient > MUL_W'(FS_CODE))
                     ? FS_CODE : w_div_rsp.quotient[CODE_W-1:0];

    // Gain must land in 1..65535
    assign w_quot_bad = (w_div_rsp.quotient == '0)
                     || (w_div_rsp.quotient[MUL_W-1:GAIN_W] != '0);

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    assign w_div_req.start    = (r_state == ogc_pkg::S_DIV);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_den;

    ogc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ogc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ogc_pkg::S_CHECK;
                end
            end
            ogc_pkg::S_CHECK: begin
                n_state = ogc_pkg::S_FINISH;
                case (r_action)
                    ogc_pkg::ACT_APPLY: begin
                        if (w_sum_pos) begin
                            n_state = ogc_pkg::S_MUL;
                        end
                    end
                    ogc_pkg::ACT_SET_GAIN: begin
                        if (!w_gain_bad) begin
                            n_state = ogc_pkg::S_MUL;
                        end
                    end
                    default: n_state = ogc_pkg::S_FINISH;
                endcase
            end
            ogc_pkg::S_MUL: n_state = ogc_pkg::S_DIV;
            ogc_pkg::S_DIV: n_state = ogc_pkg::S_WAIT;
            ogc_pkg::S_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = (r_phase == ogc_pkg::PH_TARGET)
                            ? ogc_pkg::S_MUL : ogc_pkg::S_FINISH;
                end
            end
            ogc_pkg::S_FINISH: begin
                if (w_slot_free) begin
                    n_state = ogc_pkg::S_IDLE;
                end
            end
            default: n_state = ogc_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready  = (r_state == ogc_pkg::S_IDLE);
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_gain      = r_gain;
        n_action    = r_action;
        n_sample    = r_sample;
        n_mv        = r_mv;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_prod      = r_prod;
        n_den       = r_den;
        n_base      = r_base;
        n_corr      = r_corr;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ogc_pkg::S_IDLE: begin
                // latch the word and clear the result fields
                if (w_accept) begin
                    n_action = i_in_data.action;
                    n_sample = i_in_data.sample;
                    n_mv     = i_in_data.expected_mv;
                    n_corr   = '0;
                    n_status = 1'b0;
                end
            end
            ogc_pkg::S_CHECK: begin
                case (r_action)
                    ogc_pkg::ACT_APPLY: begin
                        // a non-positive sum always clamps to zero
                        n_mul_a = w_sum[CODE_W-1:0];
                        n_mul_b = r_gain;
                        n_den   = ogc_pkg::PERMILLE_DEN;
                        n_phase = ogc_pkg::PH_APPLY;
                    end
                    ogc_pkg::ACT_SET_ZERO: begin
                        if (r_sample > FS_CODE) begin
                            n_status = 1'b1;
                        end else begin
                            n_offset = OFS_W'(SUM_W'(0) - $signed({2'b00, r_sample}));
                        end
                    end
                    ogc_pkg::ACT_SET_GAIN: begin
                        if (w_gain_bad) begin
                            n_status = 1'b1;
                        end else begin
                            // expected code = mv * FS / VREF first
                            n_mul_a = r_mv;
                            n_mul_b = FS_CODE;
                            n_den   = VREF_CODE;
                            n_base  = w_sum[CODE_W-1:0];
                            n_phase = ogc_pkg::PH_TARGET;
                        end
                    end
                    default: n_status = 1'b1;
                endcase
            end
            ogc_pkg::S_MUL: begin
                n_prod = MUL_W'(r_mul_a) * MUL_W'(r_mul_b);
            end
            ogc_pkg::S_DIV: begin
                // divider latches its operands this cycle
            end
            ogc_pkg::S_WAIT: begin
                if (w_div_rsp.done) begin
                    case (r_phase)
                        ogc_pkg::PH_APPLY: begin
                            n_corr = w_clamped[CORR_W-1:0];
                        end
                        ogc_pkg::PH_TARGET: begin
                            // expected code never exceeds full scale
                            n_mul_a = w_div_rsp.quotient[CODE_W-1:0];
                            n_mul_b = ogc_pkg::PERMILLE;
                            n_den   = r_base;
                            n_phase = ogc_pkg::PH_QUOT;
                        end
                        ogc_pkg::PH_QUOT: begin
                            if (w_quot_bad) begin
                                n_status = 1'b1;
                            end else begin
                                n_gain = w_div_rsp.quotient[GAIN_W-1:0];
                            end
                        end
                        default: n_phase = ogc_pkg::PH_APPLY;
                    endcase
                end
            end
            ogc_pkg::S_FINISH: begin
                // hold until the output register is free
                if (w_slot_free) begin
                    n_out.corrected = r_corr;
                    n_out.status    = r_status;
                    n_out_valid     = 1'b1;
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ogc_pkg::S_IDLE;
            r_phase     <= ogc_pkg::PH_APPLY;
            r_offset    <= '0;
            r_gain      <= ogc_pkg::GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_sample <= n_sample;
        r_mv     <= n_mv;
        r_mul_a  <= n_mul_a;
        r_mul_b  <= n_mul_b;
        r_prod   <= n_prod;
        r_den    <= n_den;
        r_base   <= n_base;
        r_corr   <= n_corr;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_gain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain != '0)
        else $error("gain register reached zero");

    a_offset_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset[OFS_W-1] || (r_offset == '0))
        else $error("offset became positive");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("accepted a second word while one is in flight");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ogc_pkg::S_WAIT))
        else $error("divider finished outside the wait state");

endmodule

`default_nettype wire

[tb/sv/adc_offset_gain_calibrator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_offset_gain_calibrator_checker: result predictor and scoreboard
// Watches both word channels of the calibrator, keeps its own copy of the
// offset and gain, predicts one result word per accepted input word and
// compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module adc_offset_gain_calibrator_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  ogc_pkg::t_in_word  i_in_data,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  ogc_pkg::t_out_word i_out_data,
    output int                 o_pending,
    output int                 o_fail_count
);
    import ogc_pkg::*;

    localparam int FULL_SCALE    = FULL_SCALE_CODE_DEF;
    localparam int VREF_MV       = VREF_MILLIVOLTS_DEF;
    localparam int PERMILLE_ONE  = 1000;
    localparam int GAIN_AT_RESET = 1000;
    localparam int GAIN_MAX      = 65535;

    int          cal_offset;
    int unsigned cal_gain;
    t_out_word   predicted_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Predict the result word of one request and update the calibration.
    function automatic t_out_word calibrate(t_in_word w);
        t_out_word   r;
        longint      sum;
        longint      scaled;
        int unsigned target;
        int unsigned quot;
        int          base;
        r.corrected = '0;
        r.status    = 1'b0;
        case (w.action)
            ACT_APPLY: begin
                sum    = longint'(w.sample) + longint'(cal_offset);
                scaled = (sum * longint'(cal_gain)) / PERMILLE_ONE;
                if (scaled < 0) begin
                    scaled = 0;
                end else if (scaled > FULL_SCALE) begin
                    scaled = FULL_SCALE;
                end
                r.corrected = CORR_W'(scaled);
            end
            ACT_SET_ZERO: begin
                if (w.sample > FULL_SCALE) begin
                    r.status = 1'b1;
                end else begin
                    cal_offset = -int'(w.sample);
                end
            end
            ACT_SET_GAIN: begin
                if (w.sample == 0 || w.expected_mv == 0 || w.expected_mv > VREF_MV) begin
                    r.status = 1'b1;
                end else begin
                    target = w.expected_mv;
                    target = (target * FULL_SCALE) / VREF_MV;
                    base   = int'(w.sample) + cal_offset;
                    if (base <= 0) begin
                        r.status = 1'b1;
                    end else begin
                        quot = (target * PERMILLE_ONE) / base;
                        if (quot == 0 || quot > GAIN_MAX) begin
                            r.status = 1'b1;
                        end else begin
                            cal_gain = quot;
                        end
                    end
                end
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            cal_offset = 0;
            cal_gain   = GAIN_AT_RESET;
            predicted_results.delete();
        end else begin
            // Retire the result word first: it can only belong to an older request.
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result word: corrected %0d status %0d",
                           i_out_data.corrected, i_out_data.status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = predicted_results.pop_front();
                    if (i_out_data.corrected !== want.corrected) begin
                        $error("corrected: expected %0d, got %0d",
                               want.corrected, i_out_data.corrected);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_out_data.status);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_results.push_back(calibrate(i_in_data));
            end
        end
        o_pending <= predicted_results.size();
    end

endmodule

[tb/sv/adc_offset_gain_calibrator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_offset_gain_calibrator_tb: stimulus and verdict for the calibrator
// Drives a directed set of corner requests, then random phases with varying
// sender gaps and receiver stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module adc_offset_gain_calibrator_tb;
    import ogc_pkg::*;

    localparam int FULL_SCALE       = FULL_SCALE_CODE_DEF;
    localparam int VREF_MV          = VREF_MILLIVOLTS_DEF;
    localparam int RESET_CYCLES     = 10;
    localparam int RANDOM_PER_PHASE = 332;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int SETTLE_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT   = 4000;

    // Action code with no operation behind it; the block must refuse it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word  = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    int pending;
    int fail_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int quiet_cycles   = 0;
    // Last zero code the block accepted; used to aim set-gain words at good quotients.
    int zero_code      = 0;

    always #2 i_clk = ~i_clk;

    adc_offset_gain_calibrator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    adc_offset_gain_calibrator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Receiver: stall at random, or hold off for a long stretch on request so
    // that the output register and the in-flight slot fill and input stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = holds_done + 1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("adc_offset_gain_calibrator_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_in_word make_word(logic [ACTION_W-1:0] action, int sample, int mv);
        t_in_word w;
        w.action      = action;
        w.sample      = CODE_W'(sample);
        w.expected_mv = CODE_W'(mv);
        return w;
    endfunction

    // Build one random request. Most set-gain words are well formed: a legal
    // voltage and a measured code up to six times the ideal one, so the quotient
    // mostly lands in range; the rest is noise that exercises the refusal paths.
    function automatic t_in_word random_word();
        t_in_word w;
        int pick;
        int r;
        int target;
        int base;
        int measured;
        pick          = $urandom_range(0, 99);
        r             = $urandom_range(0, 9);
        w.expected_mv = CODE_W'($urandom_range(0, 65535));
        w.sample      = CODE_W'($urandom_range(0, 65535));
        if (pick < 40) begin
            w.action = ACT_APPLY;
            if (r < 7) begin
                w.sample = CODE_W'($urandom_range(0, FULL_SCALE + 400));
            end
        end else if (pick < 60) begin
            w.action = ACT_SET_ZERO;
            if (r < 5) begin
                w.sample = CODE_W'($urandom_range(0, 300));
            end else if (r < 8) begin
                w.sample = CODE_W'($urandom_range(0, FULL_SCALE));
            end
            if (w.sample <= FULL_SCALE) begin
                zero_code = w.sample;
            end
        end else if (pick < 95) begin
            w.action = ACT_SET_GAIN;
            if (r < 8) begin
                w.expected_mv = CODE_W'($urandom_range(1, VREF_MV));
                target        = (int'(w.expected_mv) * FULL_SCALE) / VREF_MV;
                base          = (target * $urandom_range(1, 600)) / 100;
                measured      = base + zero_code;
                w.sample      = CODE_W'((measured > 65535) ? 65535 : measured);
            end else if (r == 8) begin
                w.expected_mv = CODE_W'($urandom_range(0, VREF_MV + 50));
            end
        end else begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    // Offer one word, after a random gap, and hold it until it is accepted.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Drop valid and wait until every predicted result word has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners, starting from the reset calibration.
        send_word(make_word(ACT_APPLY,    0,     0));
        send_word(make_word(ACT_APPLY,    65535, 65535));   // clamp high
        send_word(make_word(ACT_APPLY,    FULL_SCALE, 0));
        send_word(make_word(ACT_APPLY,    1234,  0));
        send_word(make_word(ACT_UNUSED,   65535, 65535));   // refused action
        send_word(make_word(ACT_SET_ZERO, FULL_SCALE + 1, 0));  // just above full scale
        send_word(make_word(ACT_SET_ZERO, 65535, 0));
        send_word(make_word(ACT_SET_ZERO, FULL_SCALE, 0));  // most negative offset
        send_word(make_word(ACT_APPLY,    0,     0));       // negative sum clamps to 0
        send_word(make_word(ACT_APPLY,    65535, 0));
        send_word(make_word(ACT_SET_GAIN, 100,   1000));    // zero-corrected code negative
        send_word(make_word(ACT_SET_ZERO, 0,     0));
        send_word(make_word(ACT_SET_GAIN, 0,     1000));    // measured code zero
        send_word(make_word(ACT_SET_GAIN, 2000,  0));       // voltage zero
        send_word(make_word(ACT_SET_GAIN, 2000,  VREF_MV + 1));  // above reference
        send_word(make_word(ACT_SET_GAIN, 2000,  65535));
        send_word(make_word(ACT_SET_GAIN, 1,     VREF_MV)); // quotient too large
        send_word(make_word(ACT_SET_GAIN, 2000,  1));       // quotient zero
        send_word(make_word(ACT_SET_GAIN, 63,    VREF_MV)); // gain near the top
        send_word(make_word(ACT_APPLY,    1,     0));
        send_word(make_word(ACT_APPLY,    FULL_SCALE, 0));  // wide product, clamped
        send_word(make_word(ACT_SET_GAIN, FULL_SCALE, VREF_MV));
        send_word(make_word(ACT_SET_GAIN, 65535, VREF_MV)); // small gain
        send_word(make_word(ACT_APPLY,    65535, 0));
        send_word(make_word(ACT_SET_GAIN, 2000,  VREF_MV / 2));
        drain();

        // Random phases: no idling with a long receiver hold-off, then sender
        // gaps, receiver stalls, and both. Drain fully between phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    hold_requests <= hold_requests + 1;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 46;
                end
                default: begin
                    send_idle_pct = 34;
                    recv_stall_pct <= 34;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_word(random_word());
            end
            drain();
        end

        // Let any stray result word show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("adc_offset_gain_calibrator_tb: PASS");
        end else begin
            $display("adc_offset_gain_calibrator_tb: FAIL");
        end
        $finish;
    end

endmodule
